### rtl/svpwm_duty_from_dq_top_assert.svh
// assertion macros for the port-level checker file
`ifndef SVPWM_DUTY_FROM_DQ_TOP_ASSERT_SVH
`define SVPWM_DUTY_FROM_DQ_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SVD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion label failed");

// antecedent implies consequent in the next cycle
`define SVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion label failed");

`endif

### rtl/svd_pkg.sv
// types, constants and the sine table for the svpwm duty pipeline
package svd_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int IDX_BITS = $clog2(SINE_DEPTH);

  localparam longint unsigned SIN_A = 64'd51472;
  localparam longint unsigned SIN_B = 64'd21024;
  localparam longint unsigned SIN_C = 64'd2320;

  // sqrt(3)/2 in q16, as an 18-bit signed operand
  localparam logic signed [17:0] HALF_ROOT3 = 18'sd56756;

  // register indexes
  localparam logic [1:0] REG_DUTY_GAIN = 2'd0;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd1;
  localparam logic [15:0] PERIOD_RESET = 16'd4200;

  localparam logic [2:0] SECTOR_START = 3'd3;
  localparam logic [2:0] SECTOR_FOLD = 3'd7;

  typedef struct packed {
    logic [15:0] rotor_angle;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } cmd_t;

  typedef struct packed {
    logic [15:0] compare_u;
    logic [15:0] compare_v;
    logic [15:0] compare_w;
    logic [2:0] sector_number;
    logic duty_clamped;
  } result_t;

  // alpha/beta word between rotation and sector stages
  typedef struct packed {
    logic valid;
    logic signed [17:0] alpha;
    logic signed [17:0] beta;
  } ab_t;

  // phase terms between sector and duty stages
  typedef struct packed {
    logic valid;
    logic signed [37:0] ta;
    logic signed [37:0] tb;
    logic signed [37:0] tc;
    logic [2:0] sector;
  } phase_t;

  typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

  // quarter-wave fifth-order polynomial, saturated
  function automatic longint unsigned quarter_sine(longint unsigned z);
    longint unsigned z2;
    longint unsigned t;
    z2 = (z * z) >> 15;
    t = (SIN_C * z2) >> 15;
    t = SIN_B - t;
    t = (t * z2) >> 15;
    t = SIN_A - t;
    t = (z * t) >> 15;
    return (t > 64'd32767) ? 64'd32767 : t;
  endfunction

  // full-turn q15 table
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned ph;
    longint unsigned q;
    longint unsigned f;
    longint unsigned z;
    longint unsigned s;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      ph = ((longint'(i)) << 32) / SINE_DEPTH;
      q = (ph >> 30) & 64'd3;
      f = (ph >> 15) & 64'h7FFF;
      z = q[0] ? (64'd32768 - f) : f;
      s = quarter_sine(z);
      tab[i] = q[1] ? -$signed(s[15:0]) : $signed(s[15:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### rtl/svd_rotate.sv
// inverse park rotation: table read, four products, floored alpha/beta
module svd_rotate (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  svd_pkg::cmd_t cmd,
  output svd_pkg::ab_t ab
);

  logic [svd_pkg::IDX_BITS-1:0] idx;
  logic [svd_pkg::IDX_BITS-1:0] idx_cos;
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic signed [15:0] vd1;
  logic signed [15:0] vq1;
  logic v1;
  logic signed [31:0] p_cd;
  logic signed [31:0] p_sq;
  logic signed [31:0] p_sd;
  logic signed [31:0] p_cq;
  logic v2;
  logic signed [32:0] sum_a;
  logic signed [32:0] sum_b;

  assign idx = cmd.rotor_angle[svd_pkg::ANGLE_BITS-1 -: svd_pkg::IDX_BITS];
  assign idx_cos = idx + svd_pkg::IDX_BITS'(svd_pkg::SINE_DEPTH / 4);

  // stage 1: table read
  always_ff @(posedge clk) begin
    sn <= svd_pkg::SINE_TAB[idx];
    cs <= svd_pkg::SINE_TAB[idx_cos];
    vd1 <= cmd.volt_d;
    vq1 <= cmd.volt_q;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // stage 2: rotation products
  always_ff @(posedge clk) begin
    p_cd <= cs * vd1;
    p_sq <= sn * vq1;
    p_sd <= sn * vd1;
    p_cq <= cs * vq1;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // stage 3: sums floored by 2^15
  assign sum_a = 33'(p_cd) - 33'(p_sq);
  assign sum_b = 33'(p_sd) + 33'(p_cq);

  always_ff @(posedge clk) begin
    ab.alpha <= sum_a[32:15];
    ab.beta <= sum_b[32:15];
    if (rst) begin
      ab.valid <= 1'b0;
    end else begin
      ab.valid <= v2;
    end
  end

endmodule

### rtl/svd_sector.sv
// u1/u2/u3 terms, sector search and phase term selection
module svd_sector (
  input  logic clk,
  input  logic rst,
  input  svd_pkg::ab_t ab,
  output svd_pkg::phase_t ph
);

  logic signed [35:0] mul_a;
  logic signed [37:0] u1;
  logic signed [37:0] u2;
  logic v4;
  logic signed [37:0] u3;
  logic [2:0] sec_mid;
  logic [2:0] sector;

  assign mul_a = ab.alpha * svd_pkg::HALF_ROOT3;

  // stage 4: u1 and u2
  always_ff @(posedge clk) begin
    u1 <= 38'(ab.beta) <<< 16;
    u2 <= (38'(ab.beta) <<< 15) + 38'(mul_a);
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= ab.valid;
    end
  end

  // sector from the sign tests
  always_comb begin
    u3 = u2 - u1;
    sec_mid = svd_pkg::SECTOR_START;
    if (u2 > 0) sec_mid = sec_mid - 3'd1;
    if (u3 > 0) sec_mid = sec_mid - 3'd1;
    sector = (u1 < 0) ? (svd_pkg::SECTOR_FOLD - sec_mid) : sec_mid;
  end

  // stage 5: phase terms
  always_ff @(posedge clk) begin
    ph.sector <= sector;
    case (sector)
      3'd1, 3'd4: begin
        ph.ta <= u2;
        ph.tb <= u1 - u3;
        ph.tc <= -u2;
      end
      3'd2, 3'd5: begin
        ph.ta <= u3 + u2;
        ph.tb <= u1;
        ph.tc <= -u1;
      end
      default: begin
        ph.ta <= u3;
        ph.tb <= -u3;
        ph.tc <= -(u1 + u2);
      end
    endcase
    if (rst) begin
      ph.valid <= 1'b0;
    end else begin
      ph.valid <= v4;
    end
  end

endmodule

### rtl/svd_duty.sv
// gain scaling, duty clamp and compare conversion for three phases
module svd_duty (
  input  logic clk,
  input  logic rst,
  input  svd_pkg::phase_t ph,
  input  logic [15:0] duty_gain,
  input  logic [15:0] pwm_period,
  output logic done,
  output svd_pkg::result_t result
);

  logic signed [37:0] t_in [3];
  logic [34:0] pl [3];
  logic signed [35:0] pv [3];
  logic [2:0] sec6;
  logic v6;
  logic signed [55:0] prod [3];
  logic signed [55:0] dv [3];
  logic [32:0] duty_next [3];
  logic [2:0] clamp_next;
  logic [32:0] duty [3];
  logic clamped7;
  logic [2:0] sec7;
  logic v7;
  logic [32:0] inv [3];
  logic [47:0] cmp_prod [3];
  logic [15:0] cmp_next [3];

  assign t_in[0] = ph.ta;
  assign t_in[1] = ph.tb;
  assign t_in[2] = ph.tc;

  // stage 6: split gain products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl[k] <= t_in[k][18:0] * duty_gain;
      pv[k] <= $signed(t_in[k][37:19]) * $signed({1'b0, duty_gain});
    end
    sec6 <= ph.sector;
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= ph.valid;
    end
  end

  // recombine, halve, offset and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (56'(pv[k]) <<< 19) + $signed({21'd0, pl[k]});
      dv[k] = (prod[k] >>> 1) + (56'sd1 <<< 31);
      if (dv[k] < 0) begin
        duty_next[k] = 33'd0;
        clamp_next[k] = 1'b1;
      end else if (dv[k] > (56'sd1 <<< 32)) begin
        duty_next[k] = 33'h1_0000_0000;
        clamp_next[k] = 1'b1;
      end else begin
        duty_next[k] = dv[k][32:0];
        clamp_next[k] = 1'b0;
      end
    end
  end

  // stage 7: duties
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      duty[k] <= duty_next[k];
    end
    clamped7 <= |clamp_next;
    sec7 <= sec6;
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  // inverted duty times period
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inv[k] = 33'h1_0000_0000 - duty[k];
      cmp_prod[k] = inv[k][31:0] * pwm_period;
      cmp_next[k] = inv[k][32] ? pwm_period : cmp_prod[k][47:32];
    end
  end

  // stage 8: output word
  always_ff @(posedge clk) begin
    result.compare_u <= cmp_next[0];
    result.compare_v <= cmp_next[1];
    result.compare_w <= cmp_next[2];
    result.sector_number <= sec7;
    result.duty_clamped <= clamped7;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
  end

endmodule

### rtl/svpwm_duty_from_dq_top.sv
// svpwm duty generator top level: config registers and pipeline
// a word accepted by start enters stage 1 and raises done from stage 8
// throughput: one word per cycle outside reset; the 8 register stages never stall
// busy is high only during reset, results cannot be held off
// reset clears the valid bits, duty_gain to 0 and pwm_period to 4200
module svpwm_duty_from_dq_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  svd_pkg::cmd_t cmd,
  input  logic wr_en,
  input  logic [1:0] wr_index,
  input  logic [15:0] wr_data,
  output logic done,
  output svd_pkg::result_t result
);

  logic [15:0] duty_gain;
  logic [15:0] pwm_period;
  svd_pkg::ab_t ab;
  svd_pkg::phase_t ph;

  assign busy = rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_gain <= 16'd0;
      pwm_period <= svd_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        svd_pkg::REG_DUTY_GAIN: duty_gain <= wr_data;
        svd_pkg::REG_PWM_PERIOD: pwm_period <= wr_data;
        default: ;
      endcase
    end
  end

  svd_rotate u_rotate (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .cmd(cmd), .ab(ab)
  );

  svd_sector u_sector (.clk(clk), .rst(rst), .ab(ab), .ph(ph));

  svd_duty u_duty (
    .clk(clk), .rst(rst), .ph(ph), .duty_gain(duty_gain),
    .pwm_period(pwm_period), .done(done), .result(result)
  );

endmodule

### rtl/svd_check.sv
// port-level checker for the svpwm duty top level
`include "svpwm_duty_from_dq_top_assert.svh"

module svd_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input svd_pkg::result_t result
);

  // every word accepted outside reset comes out with done
  `SVD_ASSERT_SAME(a_latency, $past(start && !busy, 8) && !$past(rst, 8), done)
  // no result without a word accepted before
  `SVD_ASSERT_SAME(a_no_ghost, done, $past(start && !busy, 8))
  // sector is always one of the six
  `SVD_ASSERT_SAME(a_sector, done, result.sector_number != 3'd0 && result.sector_number != 3'd7)
  // busy drops once reset is released
  `SVD_ASSERT_NEXT(a_ready, !rst, !busy)

endmodule

bind svpwm_duty_from_dq_top svd_check u_check (.*);
